/* hw/rtl/mrme_pkg.sv */
// ----------------------------------------------------------------------------
// mrme_pkg: shared types and constants for the mini register machine
// Opcodes, status codes, register file sizing and the structs passed
// between the register file, the execute logic and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package mrme_pkg;

  localparam int REGISTER_COUNT = 8;
  localparam int REG_IDX_W      = $clog2(REGISTER_COUNT);
  localparam int DATA_W         = 32;
  localparam int PC_W           = 16;
  localparam int OPC_W          = 8;
  localparam int STATUS_W       = 3;
  localparam int PRINT_REG_W    = 3;

  localparam logic [OPC_W-1:0] OPC_MOV   = 8'd0;
  localparam logic [OPC_W-1:0] OPC_ADD   = 8'd1;
  localparam logic [OPC_W-1:0] OPC_SUB   = 8'd2;
  localparam logic [OPC_W-1:0] OPC_PRINT = 8'd3;
  localparam logic [OPC_W-1:0] OPC_HALT  = 8'd4;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_HALTED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_REG = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_OPC = 3'd3;
  localparam logic [STATUS_W-1:0] ST_END     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd5;

  typedef struct packed {
    logic                 en;
    logic [REG_IDX_W-1:0] addr;
    logic [DATA_W-1:0]    data;
  } rf_write_t;

  typedef struct packed {
    logic [PC_W-1:0] pc;
    logic            zflag;
    logic            stopped;
  } machine_state_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [PC_W-1:0]        fetch_index;
    logic                   print_valid;
    logic [PRINT_REG_W-1:0] print_register;
    logic [DATA_W-1:0]      print_value;
    logic                   zero_now;
  } exec_result_t;

  // A register index is legal when, read as signed, it lies in 0..REGISTER_COUNT-1.
  function automatic logic reg_ok(input logic [DATA_W-1:0] field);
    return (field[DATA_W-1] == 1'b0) && (field < DATA_W'(REGISTER_COUNT));
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/mrme_ram.sv */
// ----------------------------------------------------------------------------
// mrme_ram: generic RAM, one write port, two registered read ports
// Read data updates only on a read enable and holds otherwise.
// ----------------------------------------------------------------------------
`default_nettype none

module mrme_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/mrme_regfile.sv */
// ----------------------------------------------------------------------------
// mrme_regfile: machine register file
// RAM storage with per-entry valid bits (unwritten entries read as zero)
// and a bypass of the write that lands on the same edge as a read.
// ----------------------------------------------------------------------------
`default_nettype none

module mrme_regfile (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             re,
  input  wire logic [mrme_pkg::REG_IDX_W-1:0]   raddr_a,
  input  wire logic [mrme_pkg::REG_IDX_W-1:0]   raddr_b,
  input  wire mrme_pkg::rf_write_t              wr,
  output logic      [mrme_pkg::DATA_W-1:0]      rdata_a,
  output logic      [mrme_pkg::DATA_W-1:0]      rdata_b
);

  import mrme_pkg::*;

  logic [REGISTER_COUNT-1:0] written;
  logic [REG_IDX_W-1:0]      ra_q;
  logic [REG_IDX_W-1:0]      rb_q;
  rf_write_t                 last_wr;
  logic [DATA_W-1:0]         ram_a;
  logic [DATA_W-1:0]         ram_b;

  mrme_ram #(
    .WIDTH (DATA_W),
    .DEPTH (REGISTER_COUNT)
  ) u_ram (
    .clk     (clk),
    .we      (wr.en),
    .waddr   (wr.addr),
    .wdata   (wr.data),
    .re      (re),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (ram_a),
    .rdata_b (ram_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      last_wr.en <= 1'b0;
    end else if (wr.en) begin
      written[wr.addr] <= 1'b1;
      last_wr          <= wr;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      ra_q <= raddr_a;
      rb_q <= raddr_b;
    end
  end

  // The most recent write may have landed on the same edge as the read; take it.
  always_comb begin
    if (last_wr.en && (last_wr.addr == ra_q)) begin
      rdata_a = last_wr.data;
    end else begin
      rdata_a = written[ra_q] ? ram_a : '0;
    end
    if (last_wr.en && (last_wr.addr == rb_q)) begin
      rdata_b = last_wr.data;
    end else begin
      rdata_b = written[rb_q] ? ram_b : '0;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/mrme_exec.sv */
// ----------------------------------------------------------------------------
// mrme_exec: instruction execute logic
// Decodes one instruction, checks register indexes, computes the add or
// subtract, and produces the result beat, the write and the next state.
// ----------------------------------------------------------------------------
`default_nettype none

module mrme_exec (
  input  wire logic [mrme_pkg::OPC_W-1:0]  operation,
  input  wire logic [mrme_pkg::DATA_W-1:0] field_a,
  input  wire logic [mrme_pkg::DATA_W-1:0] field_b,
  input  wire logic [mrme_pkg::DATA_W-1:0] field_c,
  input  wire logic                        last_instruction,
  input  wire logic [mrme_pkg::DATA_W-1:0] rdata_a,
  input  wire logic [mrme_pkg::DATA_W-1:0] rdata_b,
  input  wire mrme_pkg::machine_state_t    state,
  output mrme_pkg::machine_state_t         state_next,
  output mrme_pkg::rf_write_t              wr,
  output mrme_pkg::exec_result_t           result
);

  import mrme_pkg::*;

  logic              ok_a;
  logic              ok_b;
  logic              ok_c;
  logic [DATA_W-1:0] arith;
  logic [STATUS_W-1:0] status;

  assign ok_a  = reg_ok(field_a);
  assign ok_b  = reg_ok(field_b);
  assign ok_c  = reg_ok(field_c);
  assign arith = (operation == OPC_ADD) ? (rdata_a + rdata_b) : (rdata_a - rdata_b);

  always_comb begin
    state_next            = state;
    wr                    = '0;
    status                = ST_OK;
    result.print_valid    = 1'b0;
    result.print_register = '0;
    result.print_value    = '0;

    if (state.stopped) begin
      status = ST_IGNORED;
    end else begin
      state_next.pc = state.pc + PC_W'(1);
      unique case (operation)
        OPC_MOV: begin
          if (!ok_a) begin
            status = ST_BAD_REG;
          end else begin
            wr.en   = 1'b1;
            wr.addr = field_a[REG_IDX_W-1:0];
            wr.data = field_b;
          end
        end
        OPC_ADD, OPC_SUB: begin
          if (!(ok_a && ok_b && ok_c)) begin
            status = ST_BAD_REG;
          end else begin
            state_next.zflag = (arith == '0);
            wr.en   = 1'b1;
            wr.addr = field_c[REG_IDX_W-1:0];
            wr.data = arith;
          end
        end
        OPC_PRINT: begin
          if (!ok_a) begin
            status = ST_BAD_REG;
          end else begin
            result.print_valid    = 1'b1;
            result.print_register = field_a[PRINT_REG_W-1:0];
            result.print_value    = rdata_a;
          end
        end
        OPC_HALT: begin
          status = ST_HALTED;
        end
        default: begin
          status = ST_BAD_OPC;
        end
      endcase
      if ((status == ST_OK) && last_instruction) begin
        status = ST_END;
      end
      if (status != ST_OK) begin
        state_next.stopped = 1'b1;
      end
    end

    result.status      = status;
    result.fetch_index = state.pc;
    result.zero_now    = state_next.zflag;
  end

endmodule

`default_nettype wire

/* hw/rtl/mini_register_machine_execute.sv */
// ----------------------------------------------------------------------------
// mini_register_machine_execute: one instruction per beat, 8-entry register file
// The result passes through the input (execute) register, then the output register;
// throughput 1 beat/cycle while the result side does not stall, set by the single execute
// stage fed by the registered register-file reads.
// Synchronous reset clears registers to zero, PC, zero flag and stop flag.
// ----------------------------------------------------------------------------
`default_nettype none

module mini_register_machine_execute (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // input channel
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic        [mrme_pkg::OPC_W-1:0]  operation,
  input  wire logic signed [mrme_pkg::DATA_W-1:0] field_a,
  input  wire logic signed [mrme_pkg::DATA_W-1:0] field_b,
  input  wire logic signed [mrme_pkg::DATA_W-1:0] field_c,
  input  wire logic                               last_instruction,
  // result channel
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [mrme_pkg::STATUS_W-1:0]           status,
  output logic [mrme_pkg::PC_W-1:0]               fetch_index,
  output logic                                    print_valid,
  output logic [mrme_pkg::PRINT_REG_W-1:0]        print_register,
  output logic signed [mrme_pkg::DATA_W-1:0]      print_value,
  output logic                                    zero_now
);

  import mrme_pkg::*;

  // Pipeline:
  //   accept edge : instruction fields captured into the execute register, and
  //                 the two source registers are read from the RAM at the same edge.
  //   execute     : decode, index checks, add/sub, write-back, state update; the
  //                 result beat is captured into the output register.
  // The register-file write of one instruction lands on the same edge that the
  // next instruction's reads are issued; the register file bypasses it.

  logic                 in_accept;
  logic                 x_valid;
  logic                 x_adv;
  logic [OPC_W-1:0]     x_operation;
  logic [DATA_W-1:0]    x_field_a;
  logic [DATA_W-1:0]    x_field_b;
  logic [DATA_W-1:0]    x_field_c;
  logic                 x_last;

  logic [DATA_W-1:0]    rdata_a;
  logic [DATA_W-1:0]    rdata_b;
  rf_write_t            exec_wr;
  rf_write_t            rf_wr;
  machine_state_t       state;
  machine_state_t       state_next;
  exec_result_t         exec_result;
  exec_result_t         out_q;

  assign in_accept = in_valid && !in_stall;
  // Advance the execute stage when the output register is empty or draining.
  assign x_adv     = x_valid && (!out_valid || !out_stall);
  // Hold the input only when the execute stage is full and cannot move on.
  assign in_stall  = x_valid && !x_adv;

  // Execute-stage control.
  always_ff @(posedge clk) begin
    if (rst) begin
      x_valid <= 1'b0;
    end else if (in_accept) begin
      x_valid <= 1'b1;
    end else if (x_adv) begin
      x_valid <= 1'b0;
    end
  end

  // Execute-stage payload.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      x_operation <= operation;
      x_field_a   <= field_a;
      x_field_b   <= field_b;
      x_field_c   <= field_c;
      x_last      <= last_instruction;
    end
  end

  // Only a beat that actually leaves the execute stage commits its write.
  always_comb begin
    rf_wr    = exec_wr;
    rf_wr.en = exec_wr.en && x_adv;
  end

  mrme_regfile u_regfile (
    .clk     (clk),
    .rst     (rst),
    .re      (in_accept),
    .raddr_a (field_a[REG_IDX_W-1:0]),
    .raddr_b (field_b[REG_IDX_W-1:0]),
    .wr      (rf_wr),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  mrme_exec u_exec (
    .operation        (x_operation),
    .field_a          (x_field_a),
    .field_b          (x_field_b),
    .field_c          (x_field_c),
    .last_instruction (x_last),
    .rdata_a          (rdata_a),
    .rdata_b          (rdata_b),
    .state            (state),
    .state_next       (state_next),
    .wr               (exec_wr),
    .result           (exec_result)
  );

  // Machine state: PC, zero flag and stop flag advance with each executed beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (x_adv) begin
      state <= state_next;
    end
  end

  // Output register: load on advance, drop valid once the beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (x_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (x_adv) begin
      out_q <= exec_result;
    end
  end

  assign status         = out_q.status;
  assign fetch_index    = out_q.fetch_index;
  assign print_valid    = out_q.print_valid;
  assign print_register = out_q.print_register;
  assign print_value    = out_q.print_value;
  assign zero_now       = out_q.zero_now;

endmodule

`default_nettype wire

/* tb/sv/mini_register_machine_execute_tb.sv */
// ----------------------------------------------------------------------------
// mini_register_machine_execute_tb: self-checking bench for the execute block
// Runs one long program through the machine: a directed opener on wraparound
// and the zero flag, a random program with bursty idling on both channels
// and a quiet final stretch, then one stopping instruction and a tail of
// random beats that must all come back ignored.
// Every result beat is checked field by field against an in-bench machine.
// ----------------------------------------------------------------------------
`default_nettype none

module mini_register_machine_execute_tb;
  import mrme_pkg::*;

  // Tracks the architectural state of the machine and the results it owes.
  class machine_tracker;
    logic [DATA_W-1:0] regs [REGISTER_COUNT];
    logic [PC_W-1:0]   pc;
    logic              zflag;
    logic              stopped;
    exec_result_t      pending_results [$];
    int                fail_count;

    function new();
      for (int i = 0; i < REGISTER_COUNT; i++) regs[i] = '0;
      pc = '0;
      zflag = 1'b0;
      stopped = 1'b0;
      fail_count = 0;
    endfunction

    function bit index_legal(logic [DATA_W-1:0] f);
      return ($signed(f) >= 0) && ($signed(f) < REGISTER_COUNT);
    endfunction

    task report_mismatch(string msg);
      fail_count++;
      $display("mismatch: %s", msg);
    endtask

    // Apply one accepted instruction and queue the result it must produce.
    function void note_instruction(logic [OPC_W-1:0] op, logic [DATA_W-1:0] a,
                                   logic [DATA_W-1:0] b, logic [DATA_W-1:0] c,
                                   logic lst);
      exec_result_t r;
      logic [DATA_W-1:0] sum;
      r = '0;
      r.fetch_index = pc;
      if (stopped) begin
        r.status = ST_IGNORED;
      end else begin
        pc = pc + 1'b1;
        r.status = ST_OK;
        case (op)
          OPC_MOV: begin
            if (!index_legal(a)) r.status = ST_BAD_REG;
            else regs[a[REG_IDX_W-1:0]] = b;
          end
          OPC_ADD, OPC_SUB: begin
            if (!index_legal(a) || !index_legal(b) || !index_legal(c)) begin
              r.status = ST_BAD_REG;
            end else begin
              if (op == OPC_ADD) sum = regs[a[REG_IDX_W-1:0]] + regs[b[REG_IDX_W-1:0]];
              else sum = regs[a[REG_IDX_W-1:0]] - regs[b[REG_IDX_W-1:0]];
              zflag = (sum == '0);
              regs[c[REG_IDX_W-1:0]] = sum;
            end
          end
          OPC_PRINT: begin
            if (!index_legal(a)) begin
              r.status = ST_BAD_REG;
            end else begin
              r.print_valid = 1'b1;
              r.print_register = a[PRINT_REG_W-1:0];
              r.print_value = regs[a[REG_IDX_W-1:0]];
            end
          end
          OPC_HALT: r.status = ST_HALTED;
          default:  r.status = ST_BAD_OPC;
        endcase
        if (r.status == ST_OK && lst) r.status = ST_END;
        if (r.status != ST_OK) stopped = 1'b1;
      end
      r.zero_now = zflag;
      pending_results.push_back(r);
    endfunction

    // Compare one result beat against the oldest owed result.
    task check_result(exec_result_t got);
      exec_result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result beat with none owed (fetch_index %0d)",
                                  got.fetch_index));
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("pc %0d status got %0d want %0d",
                                  want.fetch_index, got.status, want.status));
      if (got.fetch_index !== want.fetch_index)
        report_mismatch($sformatf("fetch_index got %0d want %0d",
                                  got.fetch_index, want.fetch_index));
      if (got.print_valid !== want.print_valid)
        report_mismatch($sformatf("pc %0d print_valid got %0b want %0b",
                                  want.fetch_index, got.print_valid, want.print_valid));
      if (got.print_register !== want.print_register)
        report_mismatch($sformatf("pc %0d print_register got %0d want %0d",
                                  want.fetch_index, got.print_register,
                                  want.print_register));
      if (got.print_value !== want.print_value)
        report_mismatch($sformatf("pc %0d print_value got %0h want %0h",
                                  want.fetch_index, got.print_value, want.print_value));
      if (got.zero_now !== want.zero_now)
        report_mismatch($sformatf("pc %0d zero_now got %0b want %0b",
                                  want.fetch_index, got.zero_now, want.zero_now));
    endtask
  endclass

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       in_valid;
  logic                       in_stall;
  logic [OPC_W-1:0]           operation;
  logic signed [DATA_W-1:0]   field_a;
  logic signed [DATA_W-1:0]   field_b;
  logic signed [DATA_W-1:0]   field_c;
  logic                       last_instruction;
  logic                       out_valid;
  logic                       out_stall;
  logic [STATUS_W-1:0]        status;
  logic [PC_W-1:0]            fetch_index;
  logic                       print_valid;
  logic [PRINT_REG_W-1:0]     print_register;
  logic signed [DATA_W-1:0]   print_value;
  logic                       zero_now;

  machine_tracker tracker;
  bit             gaps_on;      // random idling on both channels
  int             hold_cycles;  // long receiver hold-off, counted down below

  mini_register_machine_execute dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .operation        (operation),
    .field_a          (field_a),
    .field_b          (field_b),
    .field_c          (field_c),
    .last_instruction (last_instruction),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .status           (status),
    .fetch_index      (fetch_index),
    .print_valid      (print_valid),
    .print_register   (print_register),
    .print_value      (print_value),
    .zero_now         (zero_now)
  );

  always #10 clk = ~clk;

  // Result side: decide the stall for the next cycle with one assignment per edge.
  // A pending long hold-off wins over the random bursts.
  initial begin : stall_driver
    int burst_left;
    burst_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        out_stall <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 6) == 0) begin
        burst_left = $urandom_range(1, 3) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Sample result beats at the edge that accepts them; outputs still hold
  // their pre-edge values here since the block updates through nonblocking writes.
  always @(posedge clk) begin
    exec_result_t got;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      got.status         = status;
      got.fetch_index    = fetch_index;
      got.print_valid    = print_valid;
      got.print_register = print_register;
      got.print_value    = print_value;
      got.zero_now       = zero_now;
      tracker.check_result(got);
    end
  end

  // Offer one instruction beat, optionally after a short gap, and hold it
  // until the block takes it. Payload only changes after acceptance.
  task automatic send_instruction(logic [OPC_W-1:0] op, logic [DATA_W-1:0] a,
                                  logic [DATA_W-1:0] b, logic [DATA_W-1:0] c,
                                  logic lst);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    operation        <= op;
    field_a          <= a;
    field_b          <= b;
    field_c          <= c;
    last_instruction <= lst;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    tracker.note_instruction(op, a, b, c, lst);
  endtask

  // One well-formed, non-final instruction with random content.
  task automatic issue_program_step();
    int pick;
    logic [OPC_W-1:0]  op;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] c;
    pick = $urandom_range(0, 99);
    a = $urandom_range(0, REGISTER_COUNT - 1);
    b = $urandom_range(0, REGISTER_COUNT - 1);
    c = $urandom_range(0, REGISTER_COUNT - 1);
    if (pick < 30) begin
      op = OPC_MOV;
      c = $urandom();
      // mix full-width immediates with values that make sums wrap or cancel
      case ($urandom_range(0, 5))
        0:       b = 32'h7fff_ffff;
        1:       b = 32'h8000_0000;
        2:       b = 32'hffff_ffff;
        3:       b = $urandom_range(0, 3);
        default: b = $urandom();
      endcase
    end else if (pick < 55) begin
      op = OPC_ADD;
    end else if (pick < 80) begin
      op = OPC_SUB;
    end else begin
      op = OPC_PRINT;
      b = $urandom();
      c = $urandom();
    end
    send_instruction(op, a, b, c, 1'b0);
  endtask

  function automatic logic [DATA_W-1:0] illegal_index();
    case ($urandom_range(0, 3))
      0:       return $urandom() | 32'h8000_0000;
      1:       return REGISTER_COUNT;
      2:       return 32'hffff_ffff;
      default: return $urandom_range(REGISTER_COUNT, 32'h7fff_ffff);
    endcase
  endfunction

  initial begin : stimulus
    logic [OPC_W-1:0]  op;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] c;
    logic              lst;
    int                bad_mask;

    tracker = new();
    gaps_on = 1'b0;
    hold_cycles = 0;
    rst              <= 1'b1;
    in_valid         <= 1'b0;
    operation        <= OPC_MOV;
    field_a          <= '0;
    field_b          <= '0;
    field_c          <= '0;
    last_instruction <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed opener: extremes of the immediate, signed overflow both ways,
    // sums and differences that land on zero, and a print of every register.
    // Fields an opcode does not use mostly carry full-width noise.
    send_instruction(OPC_MOV, 0, 32'h7fff_ffff, 32'hffff_ffff, 1'b0);
    send_instruction(OPC_MOV, 1, 32'h8000_0000, 32'h0000_0000, 1'b0);
    send_instruction(OPC_ADD, 0, 1, 2, 1'b0);            // max + min -> all ones
    send_instruction(OPC_MOV, 3, 32'h0000_0001, $urandom(), 1'b0);
    send_instruction(OPC_ADD, 2, 3, 4, 1'b0);            // wraps to zero, flag set
    send_instruction(OPC_SUB, 1, 3, 5, 1'b0);            // min - 1 wraps to max
    send_instruction(OPC_ADD, 0, 3, 6, 1'b0);            // max + 1 wraps to min
    send_instruction(OPC_SUB, 5, 0, 6, 1'b0);            // equal operands, flag set
    send_instruction(OPC_MOV, 7, 32'hffff_ffff, $urandom(), 1'b0);
    send_instruction(OPC_ADD, 7, 7, 7, 1'b0);            // sources and destination alias
    send_instruction(OPC_SUB, 4, 7, 4, 1'b0);            // 0 - (-2), flag clears
    send_instruction(OPC_MOV, 0, 32'h0000_0000, $urandom(), 1'b0);
    for (int r = 0; r < REGISTER_COUNT; r++)
      send_instruction(OPC_PRINT, r, $urandom(), $urandom(), 1'b0);

    // Random program with bursty idling that switches on and off in stretches;
    // the final stretch runs back to back.
    for (int n = 0; n < 1620; n++) begin
      if (n % 150 == 0) gaps_on = (n < 1350) && ($urandom_range(0, 3) != 0);
      // fill the block: receiver holds off while the sender keeps offering
      if (n == 500) hold_cycles = 80;
      // drain completely before carrying on
      if (n == 1000) begin
        in_valid <= 1'b0;
        while (tracker.pending_results.size() != 0) @(posedge clk);
      end
      issue_program_step();
    end
    gaps_on = 1'b0;

    // One instruction that stops the machine; its kind is left to the seed.
    a = $urandom_range(0, REGISTER_COUNT - 1);
    b = $urandom_range(0, REGISTER_COUNT - 1);
    c = $urandom_range(0, REGISTER_COUNT - 1);
    lst = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0: begin
        op = OPC_HALT;                                   // halts even when marked last
      end
      1: begin
        op = OPC_W'($urandom_range(OPC_HALT + 1, 255));  // unknown opcode
      end
      2: begin
        case ($urandom_range(0, 3))                      // normal end of program
          0:       op = OPC_MOV;
          1:       op = OPC_ADD;
          2:       op = OPC_SUB;
          default: op = OPC_PRINT;
        endcase
        lst = 1'b1;
      end
      default: begin
        // bad register index; add and sub get any mix of bad fields
        case ($urandom_range(0, 3))
          0:       op = OPC_MOV;
          1:       op = OPC_ADD;
          2:       op = OPC_SUB;
          default: op = OPC_PRINT;
        endcase
        if (op == OPC_ADD || op == OPC_SUB) bad_mask = $urandom_range(1, 7);
        else bad_mask = 1;
        if (bad_mask & 1) a = illegal_index();
        if (bad_mask & 2) b = illegal_index();
        if (bad_mask & 4) c = illegal_index();
      end
    endcase
    send_instruction(op, a, b, c, lst);

    // Stopped: every further beat must come back ignored with state untouched.
    send_instruction(8'hff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
    send_instruction(OPC_MOV, 32'h0, 32'h0, 32'h0, 1'b0);
    for (int n = 0; n < 150; n++)
      send_instruction(OPC_W'($urandom_range(0, 255)), $urandom(), $urandom(),
                       $urandom(), 1'($urandom_range(0, 1)));
    in_valid <= 1'b0;

    // Wait for every owed result, then a little longer to catch strays.
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (tracker.fail_count == 0) begin
      $display("mini_register_machine_execute_tb: PASS");
    end else begin
      $display("mini_register_machine_execute_tb: FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #5000000;
    $display("mini_register_machine_execute_tb: FAIL");
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
hw/rtl/mrme_pkg.sv
hw/rtl/mrme_ram.sv
hw/rtl/mrme_regfile.sv
hw/rtl/mrme_exec.sv
hw/rtl/mini_register_machine_execute.sv
tb/sv/mini_register_machine_execute_tb.sv
